>>> rtl/core/mbz_pkg.sv
package mbz_pkg;

  localparam int unsigned MaxPointsX = 8;
  localparam int unsigned MaxPointsY = 8;
  localparam int unsigned FracBits   = 16;

  typedef enum logic [1:0] {
    MODE_WRITE    = 2'd0,
    MODE_TO_WORK  = 2'd1,
    MODE_TO_MOTOR = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_CELL_DX    = 3'd2,
    REG_CELL_DY    = 3'd3,
    REG_POINTS_X   = 3'd4,
    REG_POINTS_Y   = 3'd5,
    REG_MESH_VALID = 3'd6,
    REG_LIVE_Z     = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [2:0]         col_index;
    logic [2:0]         row_index;
    logic signed [31:0] point_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] level_offset;
    logic signed [31:0] adjusted_z;
  } out_t;

  // Per-item control and payload that rides alongside the arithmetic.
  typedef struct packed {
    logic               is_write;
    logic               wr_ok;
    logic               to_motor;
    logic signed [31:0] pos_z;
    logic [2:0]         col;
    logic [2:0]         row;
    logic signed [31:0] value;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [32:0] rel_x;
    logic signed [32:0] rel_y;
  } entry_t;

endpackage

>>> rtl/core/mesh_bilinear_z_offset.sv
// Mesh bed leveling Z correction. Write items load one probed height offset into the mesh
// store; query items give the bilinearly interpolated offset at an X/Y position and the
// corrected Z (mode 1 subtracts live Z and the offset, mode 2 adds them). The mesh store
// reads as zero after reset without any clearing pass. The block takes one item per cycle
// while in_stall_o is low; each query passes from acceptance through the queue hop, the
// divider pipeline that resolves one quotient bit per stage for the cell index and
// fraction, and then the store read and the multiply stages of the interpolation.
// Configuration must be written only while no item is in flight.
module mesh_bilinear_z_offset #(
  parameter int unsigned MAX_POINTS_X = mbz_pkg::MaxPointsX,
  parameter int unsigned MAX_POINTS_Y = mbz_pkg::MaxPointsY,
  parameter int unsigned FRAC_BITS    = mbz_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mbz_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mbz_pkg::out_t out_data_o
);

  logic signed [31:0] origin_x_q, origin_y_q, live_z_q;
  logic [30:0]        cell_dx_q, cell_dy_q;
  logic [3:0]         points_x_q, points_y_q;
  logic               mesh_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= 32'sd0;
      origin_y_q   <= 32'sd0;
      cell_dx_q    <= 31'd1638400;
      cell_dy_q    <= 31'd1747627;
      points_x_q   <= 4'd6;
      points_y_q   <= 4'd4;
      mesh_valid_q <= 1'b0;
      live_z_q     <= 32'sd0;
    end else if (cfg_we_i) begin
      unique case (mbz_pkg::reg_e'(cfg_idx_i))
        mbz_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        mbz_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        mbz_pkg::REG_CELL_DX:    cell_dx_q    <= cfg_data_i[30:0];
        mbz_pkg::REG_CELL_DY:    cell_dy_q    <= cfg_data_i[30:0];
        mbz_pkg::REG_POINTS_X:   points_x_q   <= cfg_data_i[3:0];
        mbz_pkg::REG_POINTS_Y:   points_y_q   <= cfg_data_i[3:0];
        mbz_pkg::REG_MESH_VALID: mesh_valid_q <= cfg_data_i[0];
        mbz_pkg::REG_LIVE_Z:     live_z_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic            q_full, q_push, q_pop, q_valid;
  mbz_pkg::entry_t q_in, q_out;

  mbz_front #(
    .MAX_POINTS_X(MAX_POINTS_X),
    .MAX_POINTS_Y(MAX_POINTS_Y)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .origin_x_i(origin_x_q),
    .origin_y_i(origin_y_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  mbz_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_out)
  );

  mbz_back #(
    .MAX_POINTS_X(MAX_POINTS_X),
    .MAX_POINTS_Y(MAX_POINTS_Y),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .cell_dx_i   (cell_dx_q),
    .cell_dy_i   (cell_dy_q),
    .points_x_i  (points_x_q),
    .points_y_i  (points_y_q),
    .mesh_valid_i(mesh_valid_q),
    .live_z_i    (live_z_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/mbz_ram.sv
module mbz_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> rtl/core/mbz_front.sv
module mbz_front #(
  parameter int unsigned MAX_POINTS_X = mbz_pkg::MaxPointsX,
  parameter int unsigned MAX_POINTS_Y = mbz_pkg::MaxPointsY
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mbz_pkg::in_t       in_data_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mbz_pkg::entry_t    q_entry_o
);

  localparam logic [5:0] ColLim = 6'(MAX_POINTS_X);
  localparam logic [5:0] RowLim = 6'(MAX_POINTS_Y);

  mbz_pkg::mode_e mode;

  always_comb begin
    mode = mbz_pkg::mode_e'(in_data_i.mode);
    q_entry_o.rel_x = {in_data_i.pos_x[31], in_data_i.pos_x} - {origin_x_i[31], origin_x_i};
    q_entry_o.rel_y = {in_data_i.pos_y[31], in_data_i.pos_y} - {origin_y_i[31], origin_y_i};
    q_entry_o.side.is_write = (mode == mbz_pkg::MODE_WRITE);
    q_entry_o.side.wr_ok    = ({3'b000, in_data_i.col_index} < ColLim) &&
                              ({3'b000, in_data_i.row_index} < RowLim);
    q_entry_o.side.to_motor = (mode == mbz_pkg::MODE_TO_MOTOR);
    q_entry_o.side.pos_z    = in_data_i.pos_z;
    q_entry_o.side.col      = in_data_i.col_index;
    q_entry_o.side.row      = in_data_i.row_index;
    q_entry_o.side.value    = in_data_i.point_value;
    // The unused mode is taken and dropped here.
    q_push_o   = in_valid_i && !q_full_i && (mode != mbz_pkg::MODE_NONE);
    in_stall_o = q_full_i;
  end

endmodule

>>> rtl/core/mbz_queue.sv
module mbz_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbz_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mbz_pkg::entry_t entry_o
);

  mbz_pkg::entry_t mem_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == 2'd2);
    valid_o = (cnt_q != 2'd0);
    entry_o = mem_q[rptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wptr_d  = do_push ? !wptr_q : wptr_q;
    rptr_d  = do_pop ? !rptr_q : rptr_q;
    cnt_d   = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/mbz_axis.sv
module mbz_axis #(
  parameter int unsigned IW = 3,
  parameter int unsigned FB = mbz_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] rel_i,
  input  logic [30:0]        spacing_i,
  input  logic [IW-1:0]      last_i,
  output logic [IW-1:0]      lo_o,
  output logic [IW-1:0]      hi_o,
  output logic [FB:0]        frac_o
);

  localparam int unsigned N  = IW + FB;
  localparam int unsigned RW = 33 + IW;

  logic [RW-1:0] r_q  [N+1];
  logic [N-1:0]  qq_q [N+1];
  logic          neg_q[N+1];
  logic          sat_q[N+1];
  logic [RW-1:0] r_d  [N];
  logic          bit_d[N];
  logic [IW-1:0] idx;

  // One quotient bit per stage: the cell index bits first, then the fraction bits.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      if (s < int'(IW)) begin
        if (r_q[s] >= (RW'(spacing_i) << (int'(IW) - 1 - s))) begin
          r_d[s]   = r_q[s] - (RW'(spacing_i) << (int'(IW) - 1 - s));
          bit_d[s] = 1'b1;
        end else begin
          r_d[s]   = r_q[s];
          bit_d[s] = 1'b0;
        end
      end else begin
        if ((r_q[s] << 1) >= RW'(spacing_i)) begin
          r_d[s]   = (r_q[s] << 1) - RW'(spacing_i);
          bit_d[s] = 1'b1;
        end else begin
          r_d[s]   = r_q[s] << 1;
          bit_d[s] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= RW'(rel_i[31:0]);
      qq_q[0]  <= '0;
      neg_q[0] <= rel_i[32];
      sat_q[0] <= RW'(rel_i[31:0]) >= (RW'(spacing_i) << IW);
      for (int s = 0; s < N; s++) begin
        r_q[s+1]   <= r_d[s];
        qq_q[s+1]  <= {qq_q[s][N-2:0], bit_d[s]};
        neg_q[s+1] <= neg_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  always_comb begin
    idx = qq_q[N][N-1:FB];
    if (neg_q[N]) begin
      lo_o   = '0;
      hi_o   = '0;
      frac_o = {1'b1, FB'(0)};
    end else if (sat_q[N] || (idx > last_i)) begin
      lo_o   = last_i;
      hi_o   = last_i;
      frac_o = {1'b1, FB'(0)};
    end else begin
      lo_o   = idx;
      hi_o   = (idx == last_i) ? last_i : idx + 1'b1;
      frac_o = {1'b0, qq_q[N][FB-1:0]};
    end
  end

endmodule

>>> rtl/core/mbz_back.sv
module mbz_back #(
  parameter int unsigned MAX_POINTS_X = mbz_pkg::MaxPointsX,
  parameter int unsigned MAX_POINTS_Y = mbz_pkg::MaxPointsY,
  parameter int unsigned FRAC_BITS    = mbz_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mbz_pkg::entry_t    q_entry_i,
  output logic               q_pop_o,
  input  logic [30:0]        cell_dx_i,
  input  logic [30:0]        cell_dy_i,
  input  logic [3:0]         points_x_i,
  input  logic [3:0]         points_y_i,
  input  logic               mesh_valid_i,
  input  logic signed [31:0] live_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbz_pkg::out_t      out_data_o
);

  localparam int unsigned FB    = FRAC_BITS;
  localparam int unsigned XW    = $clog2(MAX_POINTS_X);
  localparam int unsigned YW    = $clog2(MAX_POINTS_Y);
  localparam int unsigned IW    = (XW > YW) ? XW : YW;
  localparam int unsigned N     = IW + FB;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned PW1   = FB + 35;
  localparam int unsigned PW2   = FB + 37;
  localparam logic signed [PW1-1:0] Half1 = PW1'(1) << (FB - 1);
  localparam logic signed [PW2-1:0] Half2 = PW2'(1) << (FB - 1);

  logic          adv;
  logic [30:0]   sp_x, sp_y;
  logic [5:0]    pts_x, pts_y;
  logic [IW-1:0] last_x, last_y;

  always_comb begin
    sp_x  = (cell_dx_i == 31'd0) ? 31'd1 : cell_dx_i;
    sp_y  = (cell_dy_i == 31'd0) ? 31'd1 : cell_dy_i;
    pts_x = (points_x_i == 4'd0) ? 6'd1 : {2'b00, points_x_i};
    pts_y = (points_y_i == 4'd0) ? 6'd1 : {2'b00, points_y_i};
    if (pts_x > 6'(MAX_POINTS_X)) begin
      pts_x = 6'(MAX_POINTS_X);
    end
    if (pts_y > 6'(MAX_POINTS_Y)) begin
      pts_y = 6'(MAX_POINTS_Y);
    end
    last_x = IW'(pts_x - 6'd1);
    last_y = IW'(pts_y - 6'd1);
  end

  // The whole back pipeline moves together whenever the output register can take an item.
  logic out_vld_q;
  assign adv     = !out_vld_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  // Sideband delay line matching the divider depth.
  logic           vld_q [N+1];
  mbz_pkg::side_t side_q[N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= N; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int s = 0; s < N; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= q_entry_i.side;
      for (int s = 0; s < N; s++) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  logic [IW-1:0] xl, xr, yb, yt;
  logic [FB:0]   fx, fy;

  mbz_axis #(.IW(IW), .FB(FB)) u_axis_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .rel_i    (q_entry_i.rel_x),
    .spacing_i(sp_x),
    .last_i   (last_x),
    .lo_o     (xl),
    .hi_o     (xr),
    .frac_o   (fx)
  );

  mbz_axis #(.IW(IW), .FB(FB)) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .rel_i    (q_entry_i.rel_y),
    .spacing_i(sp_y),
    .last_i   (last_y),
    .lo_o     (yb),
    .hi_o     (yt),
    .frac_o   (fy)
  );

  // Mesh store access: writes and reads both happen here, so they keep item order.
  mbz_pkg::side_t side_r;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  a_lb, a_lt, a_rb, a_rt;
  logic           pv_q [DEPTH];
  logic [3:0]     pvr_q;
  logic [31:0]    d_lb, d_lt, d_rb, d_rt;

  always_comb begin
    side_r = side_q[N];
    we     = adv && vld_q[N] && side_r.is_write && side_r.wr_ok;
    waddr  = {YW'(side_r.row), XW'(side_r.col)};
    a_lb   = {yb[YW-1:0], xl[XW-1:0]};
    a_lt   = {yt[YW-1:0], xl[XW-1:0]};
    a_rb   = {yb[YW-1:0], xr[XW-1:0]};
    a_rt   = {yt[YW-1:0], xr[XW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else if (we) begin
      pv_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pvr_q <= {pv_q[a_rt], pv_q[a_rb], pv_q[a_lt], pv_q[a_lb]};
    end
  end

  mbz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_l (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (side_r.value),
    .re_i    (adv),
    .raddr0_i(a_lb),
    .raddr1_i(a_lt),
    .rdata0_o(d_lb),
    .rdata1_o(d_lt)
  );

  mbz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (side_r.value),
    .re_i    (adv),
    .raddr0_i(a_rb),
    .raddr1_i(a_rt),
    .rdata0_o(d_rb),
    .rdata1_o(d_rt)
  );

  // Interpolation stages.
  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  mbz_pkg::side_t     s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [FB:0]        fx1_q, fy1_q, fx2_q, fy2_q, fx3_q, fx4_q, fx5_q;
  logic signed [31:0] lb, lt, rb, rt;
  logic signed [31:0] lb2_q, rb2_q, lb3_q, rb3_q;
  logic signed [32:0] dl2_q, dr2_q;
  logic signed [PW1-1:0] pl3_q, pr3_q;
  logic signed [33:0] a4_q, b4_q, a5_q, a6_q;
  logic signed [34:0] d5_q;
  logic signed [PW2-1:0] p6_q;
  logic signed [33:0] off;
  logic signed [31:0] off32;
  logic signed [31:0] adj;

  always_comb begin
    // An entry never written reads as zero.
    lb = pvr_q[0] ? d_lb : 32'sd0;
    lt = pvr_q[1] ? d_lt : 32'sd0;
    rb = pvr_q[2] ? d_rb : 32'sd0;
    rt = pvr_q[3] ? d_rt : 32'sd0;
    off   = a6_q + 34'((p6_q + Half2) >>> FB);
    off32 = mesh_valid_i ? off[31:0] : 32'sd0;
    if (s6_q.to_motor) begin
      adj = s6_q.pos_z + live_z_i + off32;
    end else begin
      adj = s6_q.pos_z - live_z_i - off32;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= vld_q[N];
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      out_vld_q <= v6_q && !s6_q.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= side_r;
      fx1_q <= fx;
      fy1_q <= fy;

      s2_q  <= s1_q;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      lb2_q <= lb;
      rb2_q <= rb;
      dl2_q <= {lt[31], lt} - {lb[31], lb};
      dr2_q <= {rt[31], rt} - {rb[31], rb};

      s3_q  <= s2_q;
      fx3_q <= fx2_q;
      lb3_q <= lb2_q;
      rb3_q <= rb2_q;
      pl3_q <= $signed({1'b0, fy2_q}) * dl2_q;
      pr3_q <= $signed({1'b0, fy2_q}) * dr2_q;

      s4_q  <= s3_q;
      fx4_q <= fx3_q;
      a4_q  <= {{2{lb3_q[31]}}, lb3_q} + 34'((pl3_q + Half1) >>> FB);
      b4_q  <= {{2{rb3_q[31]}}, rb3_q} + 34'((pr3_q + Half1) >>> FB);

      s5_q  <= s4_q;
      fx5_q <= fx4_q;
      a5_q  <= a4_q;
      d5_q  <= {b4_q[33], b4_q} - {a4_q[33], a4_q};

      s6_q  <= s5_q;
      a6_q  <= a5_q;
      p6_q  <= $signed({1'b0, fx5_q}) * d5_q;

      out_data_o.level_offset <= off32;
      out_data_o.adjusted_z   <= adj;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

>>> tb/sv/mesh_bilinear_z_offset_tb.sv
`timescale 1ns / 1ps

module mesh_bilinear_z_offset_tb;

  localparam int unsigned Latency    = 3 + mbz_pkg::FracBits + 9;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    mbz_pkg::in_t  item;
    logic          has_exp;
    mbz_pkg::out_t exp;
  } vec_t;

  logic  clk_i, rst_ni;
  logic  cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic  in_valid_i, in_stall_o;
  mbz_pkg::in_t  in_data_i;
  logic  out_valid_o, out_stall_i;
  mbz_pkg::out_t out_data_o;

  mesh_bilinear_z_offset dut (.*);

  // Mirror of the block's state and configuration.
  logic signed [31:0] m_origin_x, m_origin_y, m_live_adj;
  logic [30:0] m_dx, m_dy;
  logic [3:0]  m_px, m_py;
  logic        m_valid;
  logic signed [31:0] m_store [mbz_pkg::MaxPointsY][mbz_pkg::MaxPointsX];

  mbz_pkg::out_t pending_results [$];
  mbz_pkg::out_t typed_results [$];
  logic   typed_flag [$];
  int     err_cnt, result_cnt, query_cnt, write_cnt;
  longint cycle_cnt;
  int     in_idle_pct, out_stall_pct;
  bit     hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint round_q(longint p);
    return (p + (64'sd1 <<< (mbz_pkg::FracBits - 1))) >>> mbz_pkg::FracBits;
  endfunction

  function automatic void locate_axis(input longint rel, input logic [30:0] sp_reg,
                                      input logic [3:0] pts_reg, input int maxp,
                                      output int lo, output int hi, output longint frac);
    longint sp, pts, idx, rem;
    sp  = (sp_reg == '0) ? 64'sd1 : longint'(sp_reg);
    pts = (pts_reg == '0) ? 64'sd1 : longint'(pts_reg);
    if (pts > maxp) pts = maxp;
    if (rel < 0) begin
      lo = 0; hi = 0; frac = 64'sd1 <<< mbz_pkg::FracBits;
      return;
    end
    idx = rel / sp;
    if (idx > pts - 1) idx = pts - 1;
    lo = int'(idx);
    hi = int'((idx + 1 > pts - 1) ? pts - 1 : idx + 1);
    rem = rel - idx * sp;
    frac = (rem <<< mbz_pkg::FracBits) / sp;
    if (frac > (64'sd1 <<< mbz_pkg::FracBits)) frac = 64'sd1 <<< mbz_pkg::FracBits;
  endfunction

  function automatic mbz_pkg::out_t correct_z(mbz_pkg::in_t it);
    int xl, xr, yb, yt;
    longint fx, fy, a, b, off;
    mbz_pkg::out_t r;
    off = 0;
    if (m_valid) begin
      locate_axis(longint'(it.pos_x) - m_origin_x, m_dx, m_px, int'(mbz_pkg::MaxPointsX),
                  xl, xr, fx);
      locate_axis(longint'(it.pos_y) - m_origin_y, m_dy, m_py, int'(mbz_pkg::MaxPointsY),
                  yb, yt, fy);
      a = m_store[yb][xl] + round_q(fy * (longint'(m_store[yt][xl]) - m_store[yb][xl]));
      b = m_store[yb][xr] + round_q(fy * (longint'(m_store[yt][xr]) - m_store[yb][xr]));
      off = a + round_q(fx * (b - a));
    end
    r.level_offset = off[31:0];
    if (it.mode == mbz_pkg::MODE_TO_WORK) r.adjusted_z = it.pos_z - m_live_adj - off[31:0];
    else                                  r.adjusted_z = it.pos_z + m_live_adj + off[31:0];
    return r;
  endfunction

  task automatic apply_item(mbz_pkg::in_t it, logic has_exp, mbz_pkg::out_t exp);
    if (it.mode == mbz_pkg::MODE_WRITE) begin
      m_store[it.row_index][it.col_index] = it.point_value;
      write_cnt++;
    end else if (it.mode != mbz_pkg::MODE_NONE) begin
      pending_results.push_back(correct_z(it));
      typed_results.push_back(exp);
      typed_flag.push_back(has_exp);
      query_cnt++;
    end
  endtask

  task automatic send_item(mbz_pkg::in_t it, logic has_exp = 1'b0, mbz_pkg::out_t exp = '0);
    while (($urandom % 100) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_item(it, has_exp, exp);
  endtask

  task automatic set_reg(mbz_pkg::reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      mbz_pkg::REG_ORIGIN_X:   m_origin_x = val;
      mbz_pkg::REG_ORIGIN_Y:   m_origin_y = val;
      mbz_pkg::REG_CELL_DX:    m_dx = val[30:0];
      mbz_pkg::REG_CELL_DY:    m_dy = val[30:0];
      mbz_pkg::REG_POINTS_X:   m_px = val[3:0];
      mbz_pkg::REG_POINTS_Y:   m_py = val[3:0];
      mbz_pkg::REG_MESH_VALID: m_valid = val[0];
      mbz_pkg::REG_LIVE_Z:     m_live_adj = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Result checker; samples at the edge where the item is taken.
  always @(posedge clk_i) begin
    mbz_pkg::out_t exp;
    logic typed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data_o);
        err_cnt++;
      end else begin
        exp = pending_results.pop_front();
        typed = typed_flag.pop_front();
        if (typed) exp = typed_results[0];
        void'(typed_results.pop_front());
        if (out_data_o.level_offset !== exp.level_offset) begin
          $error("level_offset expected %h actual %h", exp.level_offset,
                 out_data_o.level_offset);
          err_cnt++;
        end
        if (out_data_o.adjusted_z !== exp.adjusted_z) begin
          $error("adjusted_z expected %h actual %h", exp.adjusted_z, out_data_o.adjusted_z);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= (($urandom % 100) < out_stall_pct);
  end

  function automatic mbz_pkg::in_t make_item(mbz_pkg::mode_e md, int px, int py, int pz,
                                             int c = 0, int r = 0, int v = 0);
    mbz_pkg::in_t it;
    it.mode = md; it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.col_index = 3'(c); it.row_index = 3'(r); it.point_value = v;
    return it;
  endfunction

  function automatic mbz_pkg::in_t rand_in();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(mbz_pkg::in_t)-1:0];
  endfunction

  function automatic mbz_pkg::in_t rand_query(bit in_grid);
    mbz_pkg::in_t it;
    it = rand_in();
    it.mode = $urandom_range(0, 1) ? mbz_pkg::MODE_TO_WORK : mbz_pkg::MODE_TO_MOTOR;
    if (in_grid) begin
      it.pos_x = m_origin_x + int'($urandom_range(0, 9)) * int'(m_dx) - 100
                 + int'($urandom % (m_dx + 200));
      it.pos_y = m_origin_y + int'($urandom_range(0, 9)) * int'(m_dy) - 100
                 + int'($urandom % (m_dy + 200));
    end
    return it;
  endfunction

  task automatic random_items(int n);
    mbz_pkg::in_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom % 100;
      if (pick < 25) begin
        it = rand_in();
        it.mode = mbz_pkg::MODE_WRITE;
        if (pick < 3) it.point_value = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        else if (pick < 20) it.point_value = $signed($urandom % 40000) - 20000;
      end else if (pick < 30) begin
        it = rand_in();
        it.mode = mbz_pkg::MODE_NONE;
      end else begin
        it = rand_query(pick < 85);
      end
      send_item(it);
    end
    drain();
  endtask

  task automatic set_mesh(int ox, int oy, int dx, int dy, int px, int py, int lz);
    set_reg(mbz_pkg::REG_ORIGIN_X, ox);   set_reg(mbz_pkg::REG_ORIGIN_Y, oy);
    set_reg(mbz_pkg::REG_CELL_DX, dx);    set_reg(mbz_pkg::REG_CELL_DY, dy);
    set_reg(mbz_pkg::REG_POINTS_X, px);   set_reg(mbz_pkg::REG_POINTS_Y, py);
    set_reg(mbz_pkg::REG_LIVE_Z, lz);     set_reg(mbz_pkg::REG_MESH_VALID, 1);
  endtask

  initial begin
    vec_t dir_tab [$];
    cycle_cnt = 0; err_cnt = 0; result_cnt = 0; query_cnt = 0; write_cnt = 0;
    in_idle_pct = 0; out_stall_pct = 0; hold_off = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = mbz_pkg::REG_ORIGIN_X; cfg_data_i = '0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    m_origin_x = 0; m_origin_y = 0; m_dx = 1638400; m_dy = 1747627;
    m_px = 6; m_py = 4; m_valid = 0; m_live_adj = 0;
    foreach (m_store[r, c]) m_store[r][c] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the mesh is invalid: offset zero, adjusted Z is plain Z.
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_WORK, 0, 0, 32'h7fffffff), 1,
                        '{32'sd0, 32'h7fffffff}});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_MOTOR, -1, -1, 32'h80000000), 1,
                        '{32'sd0, 32'h80000000}});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_NONE, 5, 5, 5), 0, '0});
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_exp, dir_tab[i].exp);
    drain();

    set_mesh(0, 0, 32'd1638400, 32'd1747627, 6, 4, 32'h00010000);
    dir_tab.delete();
    // Corner writes (extremes), an out-of-range-looking index, then queries.
    dir_tab.push_back('{make_item(mbz_pkg::MODE_WRITE, 0, 0, 0, 0, 0, 32'h7fffffff), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_WRITE, 0, 0, 0, 7, 7, 32'h80000000), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_WRITE, 0, 0, 0, 1, 0, 32'h00020000), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_WRITE, 0, 0, 0, 0, 1, -32'sh30000), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_WRITE, 0, 0, 0, 5, 3, 32'h00012345), 0, '0});
    // Negative position: corner 0,0 at fraction one, plus live Z.
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_MOTOR, -5, -5, 0), 1,
                        '{32'h7fffffff, 32'h8000ffff}});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_WORK, 32'h80000000, 32'h80000000, 0),
                        0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_WORK, 32'h7fffffff, 32'h7fffffff, 0),
                        0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_WORK, 819200, 873813, 12345), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_MOTOR, 1638400, 0, 32'h7fffffff), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_TO_WORK, 100, 1747627, 32'h80000000), 0, '0});
    dir_tab.push_back('{make_item(mbz_pkg::MODE_NONE, 0, 0, 0), 0, '0});
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_exp, dir_tab[i].exp);
    drain();

    // Degenerate settings: zero spacing, zero and oversize point counts.
    set_mesh(32'h80000000, 32'h7fffffff, 0, 0, 0, 15, 32'h80000000);
    send_item(make_item(mbz_pkg::MODE_TO_WORK, 32'h7fffffff, 32'h7fffffff, 7));
    send_item(make_item(mbz_pkg::MODE_TO_MOTOR, 3, 32'h7fffffff, 7));
    drain();

    set_mesh(32'h00100000, -32'sh00100000, 655, 32'h7fffffff, 8, 8, 32'h7fffffff);
    random_items(150);
    set_mesh(0, 0, 32'd1638400, 32'd1747627, 8, 8, 32'h0000c000);
    in_idle_pct = 48;
    random_items(250);
    set_mesh(-32'sh00050000, 32'h00030000, 32'd655360, 32'd983040, 2, 2, -32'sh8000);
    in_idle_pct = 0; out_stall_pct = 48;
    random_items(250);
    set_mesh(0, 0, 32'd2000000, 32'd1500000, 5, 7, 32'h12345678);
    in_idle_pct = 9; out_stall_pct = 9;
    random_items(250);
    set_reg(mbz_pkg::REG_MESH_VALID, 0);
    in_idle_pct = 0; out_stall_pct = 0;
    random_items(100);

    // Long receiver hold-off while items keep coming, to fill the pipeline.
    set_mesh(0, 0, 32'd1638400, 32'd1747627, 8, 8, 0);
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
      random_items(200);
    join

    drain();
    $display("Covered %0d queries and %0d mesh writes, %0d results checked.",
             query_cnt, write_cnt, result_cnt);
    $display("Settings included extreme origins, spacings, point counts and live Z.");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> mesh_bilinear_z_offset.f
rtl/core/mbz_pkg.sv
rtl/core/mbz_ram.sv
rtl/core/mbz_front.sv
rtl/core/mbz_queue.sv
rtl/core/mbz_axis.sv
rtl/core/mbz_back.sv
rtl/core/mesh_bilinear_z_offset.sv
tb/sv/mesh_bilinear_z_offset_tb.sv
